/* hdl/mipsx_pkg.sv */
// ----------------------------------------------------------------------------
// MIPS subset execute package
// Opcode and function codes, register file geometry and the result record
// that the execute logic hands to the pipeline.
// ----------------------------------------------------------------------------
package mipsx_pkg;

	// Register file geometry.
	localparam int REG_COUNT = 32;
	localparam int REG_AW    = 5;

	// Primary opcodes.
	localparam logic [5:0] OP_RTYPE = 6'd0;
	localparam logic [5:0] OP_J     = 6'd2;
	localparam logic [5:0] OP_BEQ   = 6'd4;
	localparam logic [5:0] OP_BNE   = 6'd5;
	localparam logic [5:0] OP_ADDI  = 6'd8;
	localparam logic [5:0] OP_SLTI  = 6'd10;
	localparam logic [5:0] OP_ANDI  = 6'd12;
	localparam logic [5:0] OP_ORI   = 6'd13;
	localparam logic [5:0] OP_LW    = 6'd35;
	localparam logic [5:0] OP_SW    = 6'd43;

	// Function codes of the R-type instructions.
	localparam logic [5:0] FN_ADD = 6'd32;
	localparam logic [5:0] FN_SUB = 6'd34;
	localparam logic [5:0] FN_AND = 6'd36;
	localparam logic [5:0] FN_OR  = 6'd37;
	localparam logic [5:0] FN_SLT = 6'd42;

	// Outcome of one instruction as seen after the execute stage.
	typedef struct packed {
		logic [31:0]       next_pc;
		logic              branch_taken;
		logic              reg_write;
		logic [REG_AW-1:0] dest_reg;
		logic [31:0]       dest_value;
		logic              mem_read;
		logic              mem_write;
		logic [29:0]       word_index;
		logic [31:0]       store_data;
		logic              unsupported;
	} ex_result_t;

endpackage

/* hdl/mipsx_rf.sv */
// ----------------------------------------------------------------------------
// MIPS subset register file
// Two synchronous read ports and one write port. Per-entry valid bits make
// every entry read as zero after reset; register zero is never written.
// ----------------------------------------------------------------------------
module mipsx_rf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      re,
	input  logic [mipsx_pkg::REG_AW-1:0] raddr_a,
	input  logic [mipsx_pkg::REG_AW-1:0] raddr_b,
	output logic [31:0]               rdata_a,
	output logic [31:0]               rdata_b,
	input  logic                      we,
	input  logic [mipsx_pkg::REG_AW-1:0] waddr,
	input  logic [31:0]               wdata
);
	import mipsx_pkg::*;

	logic [31:0]          mem [REG_COUNT];
	logic [REG_COUNT-1:0] valid_q;
	logic [31:0]          rdata_a_q;
	logic [31:0]          rdata_b_q;

	// Valid bits: cleared at reset, set by the first write of an entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Storage with write-through on a read of the entry being written.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			if (we && waddr == raddr_a) begin
				rdata_a_q <= wdata;
			end else begin
				rdata_a_q <= valid_q[raddr_a] ? mem[raddr_a] : 32'd0;
			end
			if (we && waddr == raddr_b) begin
				rdata_b_q <= wdata;
			end else begin
				rdata_b_q <= valid_q[raddr_b] ? mem[raddr_b] : 32'd0;
			end
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

/* hdl/mipsx_dmem.sv */
// ----------------------------------------------------------------------------
// MIPS subset data memory
// Single-port word memory with a registered read. After reset a clearing
// pass writes zero to every word, one per cycle, while busy is high.
// DATA_WORDS must be a power of two; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mipsx_dmem #(
	parameter int DATA_WORDS = 256,
	parameter int AW         = $clog2(DATA_WORDS)
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          busy,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);
	logic [31:0]   mem [DATA_WORDS];
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;
	logic [31:0]   rdata_q;

	// Clearing sweep over all words after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(DATA_WORDS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Storage: the sweep owns the port while it runs.
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= 32'd0;
		end else if (en && we) begin
			mem[addr] <= wdata;
		end
		if (!clr_q && en && !we) begin
			rdata_q <= mem[addr];
		end
	end

	assign busy  = clr_q;
	assign rdata = rdata_q;

endmodule

/* hdl/mipsx_exec.sv */
// ----------------------------------------------------------------------------
// MIPS subset execute logic
// Decodes one instruction with its resolved operands and program counter and
// produces the next pc, the register write, the memory access and the
// unsupported flag. Load data is merged later in the pipeline.
// ----------------------------------------------------------------------------
module mipsx_exec (
	input  logic [31:0]            instruction,
	input  logic [31:0]            pc,
	input  logic [31:0]            op_a,
	input  logic [31:0]            op_b,
	output mipsx_pkg::ex_result_t  res
);
	import mipsx_pkg::*;

	logic [5:0]        opcode;
	logic [5:0]        funct;
	logic [REG_AW-1:0] rt;
	logic [REG_AW-1:0] rd;
	logic [31:0]       imm_s;
	logic [31:0]       imm_z;
	logic [31:0]       pc4;
	logic [31:0]       ea;
	logic              wen;
	logic [REG_AW-1:0] dreg;
	logic [31:0]       dval;
	logic              bad;

	assign opcode = instruction[31:26];
	assign funct  = instruction[5:0];
	assign rt     = instruction[20:16];
	assign rd     = instruction[15:11];
	assign imm_s  = {{16{instruction[15]}}, instruction[15:0]};
	assign imm_z  = {16'd0, instruction[15:0]};
	assign pc4    = pc + 32'd4;
	assign ea     = op_a + imm_s;

	// Decode and execute.
	always_comb begin
		res              = '0;
		res.next_pc      = pc4;
		wen              = 1'b0;
		dreg             = '0;
		dval             = 32'd0;
		bad              = 1'b0;
		case (opcode)
			OP_RTYPE: begin
				wen  = 1'b1;
				dreg = rd;
				case (funct)
					FN_ADD:  dval = op_a + op_b;
					FN_SUB:  dval = op_a - op_b;
					FN_AND:  dval = op_a & op_b;
					FN_OR:   dval = op_a | op_b;
					FN_SLT:  dval = {31'd0, $signed(op_a) < $signed(op_b)};
					default: bad  = 1'b1;
				endcase
			end
			OP_ADDI: begin
				wen  = 1'b1;
				dreg = rt;
				dval = ea;
			end
			OP_SLTI: begin
				wen  = 1'b1;
				dreg = rt;
				dval = {31'd0, $signed(op_a) < $signed(imm_s)};
			end
			OP_ANDI: begin
				wen  = 1'b1;
				dreg = rt;
				dval = op_a & imm_z;
			end
			OP_ORI: begin
				wen  = 1'b1;
				dreg = rt;
				dval = op_a | imm_z;
			end
			OP_LW: begin
				wen            = 1'b1;
				dreg           = rt;
				res.mem_read   = 1'b1;
				res.word_index = ea[31:2];
			end
			OP_SW: begin
				res.mem_write  = 1'b1;
				res.word_index = ea[31:2];
				res.store_data = op_b;
			end
			OP_BEQ, OP_BNE: begin
				if ((opcode == OP_BEQ) == (op_a == op_b)) begin
					res.branch_taken = 1'b1;
					res.next_pc      = pc4 + {imm_s[29:0], 2'b00};
				end
			end
			OP_J: begin
				res.branch_taken = 1'b1;
				res.next_pc      = {pc4[31:28], instruction[25:0], 2'b00};
			end
			default: bad = 1'b1;
		endcase

		// Writes to register zero are dropped.
		if (wen && dreg == '0) begin
			wen = 1'b0;
		end
		res.reg_write  = wen;
		res.dest_reg   = wen ? dreg : '0;
		res.dest_value = (wen && !res.mem_read) ? dval : 32'd0;

		// An unsupported encoding changes nothing and holds the pc.
		if (bad) begin
			res             = '0;
			res.next_pc     = pc;
			res.unsupported = 1'b1;
		end
	end

endmodule

/* hdl/mips_subset_instruction_execute_top.sv */
// ----------------------------------------------------------------------------
// MIPS subset instruction execute, top level
// Executes add, sub, and, or, slt, addi, slti, andi, ori, lw, sw, beq, bne
// and j on a register file, a data memory and a program counter.
//
//   Channel | Signals                          | Direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_ready, instruction  | item in
//   out     | out_valid, out_ready, next_pc,   | item out
//           | branch_taken, reg_write,         |
//           | dest_reg, dest_value, mem_write, |
//           | mem_addr, mem_data, unsupported  |
//
// One item per cycle sustained while out_ready stays high; an item passes
// operand read at accept, then execute with the memory access, then
// write-back into the result register.
// After reset in_ready stays low while the data memory is being cleared.
// Register results are forwarded from write-back into execute, so dependent
// items follow each other without bubbles. A stalled output fills the two
// internal stages before in_ready falls.
// ----------------------------------------------------------------------------
module mips_subset_instruction_execute_top #(
	parameter int DATA_WORDS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        instruction,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        next_pc,
	output logic               branch_taken,
	output logic               reg_write,
	output logic [4:0]         dest_reg,
	output logic signed [31:0] dest_value,
	output logic               mem_write,
	output logic [7:0]         mem_addr,
	output logic signed [31:0] mem_data,
	output logic               unsupported
);
	import mipsx_pkg::*;

	localparam int AW = $clog2(DATA_WORDS);

	// Pipeline state.
	logic        valid_s1;
	logic [31:0] instr_s1;
	logic        valid_s2;
	ex_result_t  res_s2;
	logic [31:0] pc_q;

	// Output register.
	logic        out_valid_q;
	logic [31:0] next_pc_q;
	logic        branch_taken_q;
	logic        reg_write_q;
	logic [4:0]  dest_reg_q;
	logic [31:0] dest_value_q;
	logic        mem_write_q;
	logic [7:0]  mem_addr_q;
	logic [31:0] mem_data_q;
	logic        unsupported_q;

	// Handshake and stage movement.
	logic        out_free;
	logic        adv_s2;
	logic        free_s2;
	logic        adv_s1;
	logic        accept;
	logic        dm_busy;

	// Datapath.
	logic [31:0] rf_rdata_a;
	logic [31:0] rf_rdata_b;
	logic [31:0] dm_rdata;
	logic [31:0] wb_value;
	logic [31:0] op_a;
	logic [31:0] op_b;
	ex_result_t  res_s1;
	logic [AW+7:0] idx_wide;

	assign out_free = !out_valid_q || out_ready;
	assign adv_s2   = valid_s2 && out_free;
	assign free_s2  = !valid_s2 || out_free;
	assign adv_s1   = valid_s1 && free_s2;
	assign in_ready = (!valid_s1 || free_s2) && !dm_busy;
	assign accept   = in_valid && in_ready;

	// Register file: read at accept, written from write-back.
	mipsx_rf u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.re      (accept),
		.raddr_a (instruction[25:21]),
		.raddr_b (instruction[20:16]),
		.rdata_a (rf_rdata_a),
		.rdata_b (rf_rdata_b),
		.we      (adv_s2 && res_s2.reg_write),
		.waddr   (res_s2.dest_reg),
		.wdata   (wb_value)
	);

	// Write-back value: load data comes straight from the memory read register.
	assign wb_value = res_s2.mem_read ? dm_rdata : res_s2.dest_value;

	// Operand forwarding from the item in write-back.
	assign op_a = (valid_s2 && res_s2.reg_write && res_s2.dest_reg == instr_s1[25:21])
		? wb_value : rf_rdata_a;
	assign op_b = (valid_s2 && res_s2.reg_write && res_s2.dest_reg == instr_s1[20:16])
		? wb_value : rf_rdata_b;

	mipsx_exec u_exec (
		.instruction (instr_s1),
		.pc          (pc_q),
		.op_a        (op_a),
		.op_b        (op_b),
		.res         (res_s1)
	);

	// Data memory: accessed once as an item leaves execute.
	mipsx_dmem #(
		.DATA_WORDS (DATA_WORDS),
		.AW         (AW)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (dm_busy),
		.en     (adv_s1 && (res_s1.mem_read || res_s1.mem_write)),
		.we     (res_s1.mem_write),
		.addr   (res_s1.word_index[AW-1:0]),
		.wdata  (res_s1.store_data),
		.rdata  (dm_rdata)
	);

	// Stage valid flags, program counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			pc_q        <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				pc_q     <= res_s1.next_pc;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instruction;
		end
		if (adv_s1) begin
			res_s2 <= res_s1;
		end
	end

	// Word index zero-extended before taking the eight reported bits.
	assign idx_wide = {8'd0, res_s2.word_index[AW-1:0]};

	// Result register.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			next_pc_q      <= res_s2.next_pc;
			branch_taken_q <= res_s2.branch_taken;
			reg_write_q    <= res_s2.reg_write;
			dest_reg_q     <= res_s2.dest_reg;
			dest_value_q   <= res_s2.reg_write ? wb_value : 32'd0;
			mem_write_q    <= res_s2.mem_write;
			mem_addr_q     <= idx_wide[7:0];
			mem_data_q     <= res_s2.mem_read ? dm_rdata : res_s2.store_data;
			unsupported_q  <= res_s2.unsupported;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_pc      = next_pc_q;
	assign branch_taken = branch_taken_q;
	assign reg_write    = reg_write_q;
	assign dest_reg     = dest_reg_q;
	assign dest_value   = $signed(dest_value_q);
	assign mem_write    = mem_write_q;
	assign mem_addr     = mem_addr_q;
	assign mem_data     = $signed(mem_data_q);
	assign unsupported  = unsupported_q;

endmodule

/* tb/sv/mips_subset_instruction_execute_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIPS subset execute checker
// Watches both channels of the execute block. Every accepted instruction is
// run through a local model of the register file, data memory and program
// counter, and the outcome is queued. Every accepted result is compared with
// the oldest queued outcome. Mismatches and unexpected results are counted.
// ----------------------------------------------------------------------------
module mips_subset_instruction_execute_checker #(
	parameter int DATA_WORDS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [31:0]        instruction,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [31:0]        next_pc,
	input  logic               branch_taken,
	input  logic               reg_write,
	input  logic [4:0]         dest_reg,
	input  logic signed [31:0] dest_value,
	input  logic               mem_write,
	input  logic [7:0]         mem_addr,
	input  logic signed [31:0] mem_data,
	input  logic               unsupported,
	output int                 error_count,
	output int                 expected_count
);
	import mipsx_pkg::*;

	// Outcome of one instruction as it appears on the result channel.
	typedef struct packed {
		logic [31:0] next_pc;
		logic        branch_taken;
		logic        reg_write;
		logic [4:0]  dest_reg;
		logic [31:0] dest_value;
		logic        mem_write;
		logic [7:0]  mem_addr;
		logic [31:0] mem_data;
		logic        unsupported;
	} exec_outcome_t;

	// Architectural state of the model.
	logic [31:0] model_regs [REG_COUNT];
	logic [31:0] model_mem [DATA_WORDS];
	logic [31:0] model_pc;

	exec_outcome_t outcome_queue [$];
	logic [31:0]   issued_queue [$];

	// Executes one instruction on the model state and returns its outcome.
	function automatic exec_outcome_t execute_instruction(input logic [31:0] ins);
		logic [5:0]    opcode;
		logic [5:0]    funct;
		logic [4:0]    rs;
		logic [4:0]    rt;
		logic [4:0]    rd;
		logic [31:0]   op_a;
		logic [31:0]   op_b;
		logic [31:0]   imm_sext;
		logic [31:0]   imm_zext;
		logic [31:0]   pc_plus4;
		logic [31:0]   byte_addr;
		logic [31:0]   word_sel;
		exec_outcome_t res;
		opcode   = ins[31:26];
		rs       = ins[25:21];
		rt       = ins[20:16];
		rd       = ins[15:11];
		funct    = ins[5:0];
		imm_sext = {{16{ins[15]}}, ins[15:0]};
		imm_zext = {16'h0000, ins[15:0]};
		op_a     = (rs == 5'd0) ? 32'd0 : model_regs[rs];
		op_b     = (rt == 5'd0) ? 32'd0 : model_regs[rt];
		pc_plus4 = model_pc + 32'd4;
		byte_addr = op_a + imm_sext;
		word_sel = (byte_addr >> 2) % DATA_WORDS;
		res = '0;
		res.next_pc = pc_plus4;

		case (opcode)
			OP_RTYPE: begin
				res.reg_write = 1'b1;
				res.dest_reg  = rd;
				case (funct)
					FN_ADD: res.dest_value = op_a + op_b;
					FN_SUB: res.dest_value = op_a - op_b;
					FN_AND: res.dest_value = op_a & op_b;
					FN_OR:  res.dest_value = op_a | op_b;
					FN_SLT: res.dest_value = ($signed(op_a) < $signed(op_b)) ? 32'd1 : 32'd0;
					default: begin
						res.unsupported = 1'b1;
						res.reg_write   = 1'b0;
						res.dest_reg    = 5'd0;
					end
				endcase
			end
			OP_ADDI: begin
				res.reg_write  = 1'b1;
				res.dest_reg   = rt;
				res.dest_value = op_a + imm_sext;
			end
			OP_SLTI: begin
				res.reg_write  = 1'b1;
				res.dest_reg   = rt;
				res.dest_value = ($signed(op_a) < $signed(imm_sext)) ? 32'd1 : 32'd0;
			end
			OP_ANDI: begin
				res.reg_write  = 1'b1;
				res.dest_reg   = rt;
				res.dest_value = op_a & imm_zext;
			end
			OP_ORI: begin
				res.reg_write  = 1'b1;
				res.dest_reg   = rt;
				res.dest_value = op_a | imm_zext;
			end
			OP_LW: begin
				res.mem_addr   = word_sel[7:0];
				res.mem_data   = model_mem[word_sel];
				res.reg_write  = 1'b1;
				res.dest_reg   = rt;
				res.dest_value = model_mem[word_sel];
			end
			OP_SW: begin
				res.mem_addr  = word_sel[7:0];
				res.mem_data  = op_b;
				res.mem_write = 1'b1;
				model_mem[word_sel] = op_b;
			end
			OP_BEQ, OP_BNE: begin
				if ((opcode == OP_BEQ) == (op_a == op_b)) begin
					res.branch_taken = 1'b1;
					res.next_pc      = pc_plus4 + (imm_sext << 2);
				end
			end
			OP_J: begin
				res.branch_taken = 1'b1;
				res.next_pc      = {pc_plus4[31:28], ins[25:0], 2'b00};
			end
			default: res.unsupported = 1'b1;
		endcase

		// An unsupported encoding holds the pc; a write to register zero is dropped.
		if (res.unsupported) begin
			res.next_pc = model_pc;
		end else begin
			if (res.reg_write && res.dest_reg == 5'd0) begin
				res.reg_write  = 1'b0;
				res.dest_value = 32'd0;
			end
			if (res.reg_write) begin
				model_regs[res.dest_reg] = res.dest_value;
			end
			model_pc = res.next_pc;
		end
		if (!res.reg_write) begin
			res.dest_reg   = 5'd0;
			res.dest_value = 32'd0;
		end
		return res;
	endfunction

	// Prediction on accepted instructions and comparison on accepted results.
	always @(posedge clk or negedge arst_n) begin
		exec_outcome_t got;
		exec_outcome_t want;
		logic [31:0]   issued;
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) model_regs[i] = '0;
			for (int i = 0; i < DATA_WORDS; i++) model_mem[i] = '0;
			model_pc = '0;
			outcome_queue.delete();
			issued_queue.delete();
			error_count    = 0;
			expected_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{next_pc, branch_taken, reg_write, dest_reg, dest_value,
					mem_write, mem_addr, mem_data, unsupported};
				if (outcome_queue.size() == 0) begin
					if (error_count < 10) begin
						$display("%0t: result with no instruction pending: pc=%h", $realtime,
							next_pc);
					end
					error_count++;
				end else begin
					want   = outcome_queue.pop_front();
					issued = issued_queue.pop_front();
					if (got !== want) begin
						if (error_count < 10) begin
							$display("%0t: mismatch for instruction %h", $realtime, issued);
							$display("  expected pc=%h bt=%b rw=%b rd=%0d dv=%h mw=%b ma=%h md=%h un=%b",
								want.next_pc, want.branch_taken, want.reg_write, want.dest_reg,
								want.dest_value, want.mem_write, want.mem_addr, want.mem_data,
								want.unsupported);
							$display("  actual   pc=%h bt=%b rw=%b rd=%0d dv=%h mw=%b ma=%h md=%h un=%b",
								got.next_pc, got.branch_taken, got.reg_write, got.dest_reg,
								got.dest_value, got.mem_write, got.mem_addr, got.mem_data,
								got.unsupported);
						end
						error_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				outcome_queue.push_back(execute_instruction(instruction));
				issued_queue.push_back(instruction);
			end
			expected_count = outcome_queue.size();
		end
	end

endmodule

/* tb/sv/mips_subset_instruction_execute_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIPS subset execute testbench
// Drives directed instructions covering every opcode and the corner cases,
// then mostly well-formed random instructions with register reuse and a small
// shared memory window, with random idling on both channels, a long output
// stall and a drain pause. The checker predicts and compares the results.
// ----------------------------------------------------------------------------
module mips_subset_instruction_execute_top_test;
	import mipsx_pkg::*;

	localparam int RANDOM_ITEMS   = 900;
	localparam int HOLD_CYCLES    = 60;
	localparam int WATCHDOG_LIMIT = 2000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [31:0]        instruction;
	logic               out_valid;
	logic               out_ready;
	logic [31:0]        next_pc;
	logic               branch_taken;
	logic               reg_write;
	logic [4:0]         dest_reg;
	logic signed [31:0] dest_value;
	logic               mem_write;
	logic [7:0]         mem_addr;
	logic signed [31:0] mem_data;
	logic               unsupported;
	int                 error_count;
	int                 expected_count;

	bit idle_on;
	bit hold_out;
	int stall_cycles;

	mips_subset_instruction_execute_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.instruction  (instruction),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_pc      (next_pc),
		.branch_taken (branch_taken),
		.reg_write    (reg_write),
		.dest_reg     (dest_reg),
		.dest_value   (dest_value),
		.mem_write    (mem_write),
		.mem_addr     (mem_addr),
		.mem_data     (mem_data),
		.unsupported  (unsupported)
	);

	mips_subset_instruction_execute_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.instruction    (instruction),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.next_pc        (next_pc),
		.branch_taken   (branch_taken),
		.reg_write      (reg_write),
		.dest_reg       (dest_reg),
		.dest_value     (dest_value),
		.mem_write      (mem_write),
		.mem_addr       (mem_addr),
		.mem_data       (mem_data),
		.unsupported    (unsupported),
		.error_count    (error_count),
		.expected_count (expected_count)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Instruction encoders.
	function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
		input logic [4:0] rd, input logic [5:0] funct, input logic [4:0] shamt);
		return {OP_RTYPE, rs, rt, rd, shamt, funct};
	endfunction

	function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
		input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	// Register index biased toward a few registers so that results get reused.
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 99) < 70) return 5'($urandom_range(0, 7));
		return 5'($urandom_range(0, 31));
	endfunction

	// One random instruction, mostly from the subset.
	function automatic logic [31:0] random_instruction();
		int          kind;
		logic [5:0]  op;
		logic [5:0]  funct;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [15:0] imm;
		bit          known;
		kind = $urandom_range(0, 99);
		rs   = pick_reg();
		rt   = pick_reg();
		imm  = 16'($urandom);
		if (kind < 30) begin
			case ($urandom_range(0, 4))
				0: funct = FN_ADD;
				1: funct = FN_SUB;
				2: funct = FN_AND;
				3: funct = FN_OR;
				default: funct = FN_SLT;
			endcase
			return enc_r(rs, rt, pick_reg(), funct, 5'($urandom));
		end else if (kind < 50) begin
			case ($urandom_range(0, 3))
				0: op = OP_ADDI;
				1: op = OP_SLTI;
				2: op = OP_ANDI;
				default: op = OP_ORI;
			endcase
			return enc_i(op, rs, rt, imm);
		end else if (kind < 70) begin
			// Half the accesses hit a small window off register zero so loads see stores.
			op = (kind < 60) ? OP_SW : OP_LW;
			if ($urandom_range(0, 1) == 0) begin
				rs  = 5'd0;
				imm = 16'($urandom_range(0, 15) * 4 + $urandom_range(0, 3));
			end
			return enc_i(op, rs, rt, imm);
		end else if (kind < 80) begin
			op = ($urandom_range(0, 1) == 0) ? OP_BEQ : OP_BNE;
			if ($urandom_range(0, 1) == 0) rt = rs;
			return enc_i(op, rs, rt, imm);
		end else if (kind < 84) begin
			return {OP_J, 26'($urandom)};
		end else if (kind < 92) begin
			if ($urandom_range(0, 1) == 0) begin
				// Opcode outside the subset.
				do begin
					op = 6'($urandom_range(0, 63));
					case (op)
						OP_RTYPE, OP_J, OP_BEQ, OP_BNE, OP_ADDI, OP_SLTI, OP_ANDI, OP_ORI,
						OP_LW, OP_SW: known = 1'b1;
						default: known = 1'b0;
					endcase
				end while (known);
				return {op, 26'($urandom)};
			end
			// R-type with a function code outside the subset.
			do begin
				funct = 6'($urandom_range(0, 63));
				case (funct)
					FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT: known = 1'b1;
					default: known = 1'b0;
				endcase
			end while (known);
			return enc_r(rs, rt, pick_reg(), funct, 5'($urandom));
		end
		return 32'($urandom);
	endfunction

	// Offers one item at the falling edge and holds it until it is accepted.
	task automatic send_instruction(input logic [31:0] word);
		while (idle_on && $urandom_range(0, 99) < 38) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		instruction <= word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Result side: random idling, or a long hold when requested.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_out = 1'b0;
			end else if (idle_on) begin
				out_ready <= ($urandom_range(0, 99) >= 38);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [31:0] directed [$];
		in_valid     = 1'b0;
		instruction  = '0;
		arst_n       = 1'b0;
		idle_on      = 1'b1;
		hold_out     = 1'b0;
		stall_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Extremes of immediates, every operation and the corner cases.
		directed.push_back(enc_i(OP_ORI, 5'd0, 5'd1, 16'hFFFF));
		directed.push_back(enc_i(OP_ADDI, 5'd0, 5'd2, 16'hFFFF));
		directed.push_back(enc_i(OP_ANDI, 5'd2, 5'd3, 16'h8001));
		directed.push_back(enc_i(OP_SLTI, 5'd2, 5'd4, 16'h0000));
		directed.push_back(enc_i(OP_SLTI, 5'd1, 5'd5, 16'h8000));
		directed.push_back(enc_r(5'd2, 5'd2, 5'd6, FN_ADD, 5'd31));
		directed.push_back(enc_r(5'd0, 5'd1, 5'd7, FN_SUB, 5'd0));
		directed.push_back(enc_r(5'd1, 5'd3, 5'd8, FN_AND, 5'd0));
		directed.push_back(enc_r(5'd2, 5'd1, 5'd9, FN_OR, 5'd0));
		directed.push_back(enc_r(5'd2, 5'd1, 5'd10, FN_SLT, 5'd0));
		directed.push_back(enc_r(5'd1, 5'd2, 5'd11, FN_SLT, 5'd0));
		// Write to register zero is dropped.
		directed.push_back(enc_i(OP_ADDI, 5'd1, 5'd0, 16'h0005));
		directed.push_back(enc_r(5'd1, 5'd1, 5'd0, FN_ADD, 5'd0));
		// Misaligned and negative addresses.
		directed.push_back(enc_i(OP_SW, 5'd0, 5'd2, 16'h0003));
		directed.push_back(enc_i(OP_SW, 5'd0, 5'd1, 16'hFFFC));
		directed.push_back(enc_i(OP_LW, 5'd0, 5'd12, 16'h0000));
		directed.push_back(enc_i(OP_LW, 5'd0, 5'd0, 16'h03FC));
		directed.push_back(enc_i(OP_LW, 5'd0, 5'd13, 16'h0008));
		// Branches taken and not taken, backward and forward.
		directed.push_back(enc_i(OP_BEQ, 5'd1, 5'd1, 16'hFFFE));
		directed.push_back(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h0005));
		directed.push_back(enc_i(OP_BNE, 5'd1, 5'd2, 16'h7FFF));
		directed.push_back(enc_i(OP_BNE, 5'd0, 5'd0, 16'h0007));
		directed.push_back({OP_J, 26'h3FFFFFF});
		// Unsupported opcode and function code.
		directed.push_back({6'd63, 26'h3FFFFFF});
		directed.push_back(enc_r(5'd1, 5'd2, 5'd3, 6'd0, 5'd0));
		foreach (directed[i]) send_instruction(directed[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// A stretch without idling on either side.
			idle_on = !(i >= 350 && i < 550);
			if (i == 150) hold_out = 1'b1;
			if (i == 700) begin
				// Pause until every result has come back.
				in_valid <= 1'b0;
				do @(negedge clk); while (expected_count != 0);
			end
			send_instruction(random_instruction());
		end
		in_valid <= 1'b0;

		// Drain, then allow for the pipeline depth.
		while (expected_count != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
